// ===== design/bloom_filter_double_hash_core_macros.svh =====
// assertion macros shared by the bloom filter design files
// no dependencies
`ifndef BLOOM_FILTER_DOUBLE_HASH_CORE_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define BF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/bfdh_pkg.sv =====
// shared types and constants for the bloom filter core
// no dependencies
package bfdh_pkg;
   localparam int MAX_BITS_DEF = 65536;
   localparam int MAX_HASHES_DEF = 16;
   localparam int MAX_KEY_BYTES_DEF = 8;
   localparam logic [31:0] SEED_A = 32'd123456789;
   localparam logic [31:0] SEED_B = 32'd987654321;
   localparam logic [31:0] XP1 = 32'd2654435761;
   localparam logic [31:0] XP2 = 32'd2246822519;
   localparam logic [31:0] XP3 = 32'd3266489917;
   localparam logic [31:0] XP4 = 32'd668265263;
   localparam logic [31:0] XP5 = 32'd374761393;
   localparam logic [1:0] REG_NUM_HASHES = 2'd0;
   localparam logic [1:0] REG_NUM_BITS = 2'd1;
   localparam logic [1:0] REG_KEY_LENGTH = 2'd2;
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD, ST_PROBE, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      HS_INIT, HS_WORD_ADD, HS_WORD_ROT, HS_BYTE_ADD, HS_BYTE_ROT,
      HS_FIN_A, HS_FIN_B, HS_DONE
   } hash_state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } hash_ctl_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
      rotl = (x << r) | (x >> (6'd32 - {1'b0, r}));
   endfunction
endpackage

// ===== design/bfdh_ram.sv =====
// generic single port synchronous ram with registered read
// no dependencies
module bfdh_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== design/bfdh_hash.sv =====
// iterative xxhash32 over up to eight key bytes, both seeds in parallel
// depends on bfdh_pkg and the shared macro header
`include "bloom_filter_double_hash_core_macros.svh"
module bfdh_hash (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         key,
   input  logic [3:0]          len,
   output bfdh_pkg::hash_ctl_type ctl,
   output logic [31:0]         h1,
   output logic [31:0]         h2
);
   bfdh_pkg::hash_state_type state_ff, state_in;
   logic [31:0] ha_ff, ha_in, hb_ff, hb_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] word, byte_v, mul_a_src, mul_b_src, mul_k, pa, pb;

   always_comb begin
      word = key[{pos_ff[2], 5'd0} +: 32];
      byte_v = {24'd0, key[{pos_ff[2:0], 3'd0} +: 8]};
   end

   // one multiply pair per step, operand chosen by the step
   always_comb begin
      mul_a_src = ha_ff;
      mul_b_src = hb_ff;
      mul_k = bfdh_pkg::XP4;
      case (state_ff)
         bfdh_pkg::HS_WORD_ADD: begin
            mul_a_src = word;
            mul_b_src = word;
            mul_k = bfdh_pkg::XP3;
         end
         bfdh_pkg::HS_WORD_ROT: begin
            mul_a_src = bfdh_pkg::rotl(ha_ff, 5'd17);
            mul_b_src = bfdh_pkg::rotl(hb_ff, 5'd17);
            mul_k = bfdh_pkg::XP4;
         end
         bfdh_pkg::HS_BYTE_ADD: begin
            mul_a_src = byte_v;
            mul_b_src = byte_v;
            mul_k = bfdh_pkg::XP5;
         end
         bfdh_pkg::HS_BYTE_ROT: begin
            mul_a_src = bfdh_pkg::rotl(ha_ff, 5'd11);
            mul_b_src = bfdh_pkg::rotl(hb_ff, 5'd11);
            mul_k = bfdh_pkg::XP1;
         end
         bfdh_pkg::HS_FIN_A: begin
            mul_a_src = ha_ff ^ (ha_ff >> 15);
            mul_b_src = hb_ff ^ (hb_ff >> 15);
            mul_k = bfdh_pkg::XP2;
         end
         bfdh_pkg::HS_FIN_B: begin
            mul_a_src = ha_ff ^ (ha_ff >> 13);
            mul_b_src = hb_ff ^ (hb_ff >> 13);
            mul_k = bfdh_pkg::XP3;
         end
         default: begin
            mul_k = bfdh_pkg::XP4;
         end
      endcase
      pa = mul_a_src * mul_k;
      pb = mul_b_src * mul_k;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfdh_pkg::HS_INIT: begin
            if (start) begin
               state_in = (len >= 4'd4) ? bfdh_pkg::HS_WORD_ADD
                        : (len != 4'd0) ? bfdh_pkg::HS_BYTE_ADD : bfdh_pkg::HS_FIN_A;
            end
         end
         bfdh_pkg::HS_WORD_ADD: state_in = bfdh_pkg::HS_WORD_ROT;
         bfdh_pkg::HS_WORD_ROT: begin
            state_in = (pos_ff + 4'd4 <= len) ? bfdh_pkg::HS_WORD_ADD
                     : (pos_ff < len) ? bfdh_pkg::HS_BYTE_ADD : bfdh_pkg::HS_FIN_A;
         end
         bfdh_pkg::HS_BYTE_ADD: state_in = bfdh_pkg::HS_BYTE_ROT;
         bfdh_pkg::HS_BYTE_ROT: begin
            state_in = (pos_ff < len) ? bfdh_pkg::HS_BYTE_ADD : bfdh_pkg::HS_FIN_A;
         end
         bfdh_pkg::HS_FIN_A: state_in = bfdh_pkg::HS_FIN_B;
         bfdh_pkg::HS_FIN_B: state_in = bfdh_pkg::HS_DONE;
         bfdh_pkg::HS_DONE: state_in = bfdh_pkg::HS_INIT;
         default: state_in = bfdh_pkg::HS_INIT;
      endcase
   end

   always_comb begin
      ha_in = ha_ff;
      hb_in = hb_ff;
      pos_in = pos_ff;
      case (state_ff)
         bfdh_pkg::HS_INIT: begin
            ha_in = bfdh_pkg::SEED_A + bfdh_pkg::XP5 + {28'd0, len};
            hb_in = bfdh_pkg::SEED_B + bfdh_pkg::XP5 + {28'd0, len};
            pos_in = 4'd0;
         end
         bfdh_pkg::HS_WORD_ADD: begin
            ha_in = ha_ff + pa;
            hb_in = hb_ff + pb;
            pos_in = pos_ff + 4'd4;
         end
         bfdh_pkg::HS_BYTE_ADD: begin
            ha_in = ha_ff + pa;
            hb_in = hb_ff + pb;
            pos_in = pos_ff + 4'd1;
         end
         bfdh_pkg::HS_WORD_ROT, bfdh_pkg::HS_BYTE_ROT, bfdh_pkg::HS_FIN_A: begin
            ha_in = pa;
            hb_in = pb;
         end
         bfdh_pkg::HS_FIN_B: begin
            ha_in = pa ^ (pa >> 16);
            hb_in = pb ^ (pb >> 16);
         end
         default: begin
            ha_in = ha_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfdh_pkg::HS_INIT;
      end else begin
         state_ff <= state_in;
      end
      ha_ff <= ha_in;
      hb_ff <= hb_in;
      pos_ff <= pos_in;
   end

   always_comb begin
      ctl.start = start && (state_ff == bfdh_pkg::HS_INIT);
      ctl.busy = (state_ff != bfdh_pkg::HS_INIT);
      ctl.done = (state_ff == bfdh_pkg::HS_DONE);
   end
   assign h1 = ha_ff;
   assign h2 = hb_ff;

   `BF_ASSERT_IMP(a_pos_in_range, clock, reset, ctl.busy, pos_ff <= 4'd8,
      "hash byte position overran the key")
   `BF_ASSERT_NEXT(a_done_one_cycle, clock, reset, ctl.done, !ctl.done,
      "hash done held longer than one cycle")
   `BF_ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, ctl.busy,
      "hash did not start")
endmodule

// ===== design/bloom_filter_double_hash_core.sv =====
// bloom filter core: apb registers, hash unit, bit memory probe loop
// depends on bfdh_pkg, bfdh_hash, bfdh_ram and the shared macro header
//
// usage: req_ channel carries one transaction (operation, key). an insert
// sets the bits of num_hashes probes (clamped to MAX_HASHES) and gives no
// rsp_ transaction; a query gives one rsp_ transaction whose member bit is
// 1 if all probed bits are set. one transaction is worked at a time: the
// hash unit takes an add and a rotate step per 4-byte word and per leftover
// byte, two finish steps and a done step, then each probe is a reduction
// (mod the clamped num_bits by compare-subtract over 32 bits, one bit per
// cycle) and one read (query) or write of a 1 (insert) of the bit memory.
// the done and idle states close the transaction. after reset the bit
// memory is cleared, one entry per cycle over all MAX_BITS entries, during
// which req_ready stays low; csr writes are taken as ever. if the receiver
// stalls rsp_ready the result is held in its register; a further
// transaction is accepted and worked but holds in its done state until the
// held result is taken.
// csr map: 0x0 num_hashes, 0x4 num_bits, 0x8 key_length.
`include "bloom_filter_double_hash_core_macros.svh"
module bloom_filter_double_hash_core #(
   parameter int MAX_BITS = bfdh_pkg::MAX_BITS_DEF,
   parameter int MAX_HASHES = bfdh_pkg::MAX_HASHES_DEF,
   parameter int MAX_KEY_BYTES = bfdh_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [63:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_member,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_BITS);
   localparam int MW = $clog2(MAX_BITS + 1);
   localparam int HW = $clog2(MAX_HASHES + 1);

   logic [4:0]  num_hashes_ff;
   logic [16:0] num_bits_ff;
   logic [3:0]  key_length_ff;
   logic [1:0]  reg_ix;
   logic        csr_wr;

   bfdh_pkg::state_type state_ff, state_in;
   logic          op_ff;
   logic [63:0]   key_ff;
   logic [31:0]   h1_w, h2_w, acc_ff, acc_in, rem_ff, rem_in;
   logic [31:0]   quo_ff, quo_in;
   logic [5:0]    bit_ff, bit_in;
   logic [HW-1:0] probe_ff, probe_in, k_eff;
   logic [MW-1:0] m_eff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    ph_ff, ph_in;
   logic          all_ff, all_in, rsp_valid_ff, rsp_valid_in, rsp_member_ff;
   logic [31:0]   h2_ff, h2_in;
   logic [3:0]    len_eff;
   bfdh_pkg::hash_ctl_type hctl;
   logic          hstart;
   logic          ram_we, ram_wd, ram_rd;
   logic [AW-1:0] ram_addr;
   logic [32:0]   trial;

   assign reg_ix = csr_paddr[3:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_hashes_ff <= 5'd4;
         num_bits_ff <= 17'd65536;
         key_length_ff <= 4'd8;
      end else if (csr_wr) begin
         case (reg_ix)
            bfdh_pkg::REG_NUM_HASHES: num_hashes_ff <= csr_pwdata[4:0];
            bfdh_pkg::REG_NUM_BITS: num_bits_ff <= csr_pwdata[16:0];
            bfdh_pkg::REG_KEY_LENGTH: key_length_ff <= csr_pwdata[3:0];
            default: num_hashes_ff <= num_hashes_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_ix)
         bfdh_pkg::REG_NUM_HASHES: csr_prdata = {27'd0, num_hashes_ff};
         bfdh_pkg::REG_NUM_BITS: csr_prdata = {15'd0, num_bits_ff};
         bfdh_pkg::REG_KEY_LENGTH: csr_prdata = {28'd0, key_length_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   // clamp the configuration into the built range
   always_comb begin
      len_eff = (key_length_ff > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length_ff;
      k_eff = ({27'd0, num_hashes_ff} > 32'(MAX_HASHES)) ? HW'(MAX_HASHES)
            : HW'(num_hashes_ff);
      if (num_bits_ff == 17'd0) begin
         m_eff = MW'(1);
      end else if ({15'd0, num_bits_ff} > 32'(MAX_BITS)) begin
         m_eff = MW'(MAX_BITS);
      end else begin
         m_eff = MW'(num_bits_ff);
      end
   end

   assign hstart = (state_ff == bfdh_pkg::ST_IDLE) && req_valid && req_ready;

   // the hash reads the key from the cycle after accept, so it takes the held copy
   bfdh_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hstart),
      .key   (key_ff),
      .len   (len_eff),
      .ctl   (hctl),
      .h1    (h1_w),
      .h2    (h2_w)
   );

   // restoring remainder step: one dividend bit per cycle
   assign trial = {rem_ff, quo_ff[31]} - {{(33 - MW){1'b0}}, m_eff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(MAX_BITS - 1)) state_in = bfdh_pkg::ST_IDLE;
         end
         bfdh_pkg::ST_IDLE: if (hstart) state_in = bfdh_pkg::ST_HASH;
         bfdh_pkg::ST_HASH: begin
            if (hctl.done) begin
               state_in = (k_eff == '0) ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_MOD;
            end
         end
         bfdh_pkg::ST_MOD: if (bit_ff == 6'd31) state_in = bfdh_pkg::ST_PROBE;
         bfdh_pkg::ST_PROBE: begin
            if (ph_ff == 2'd1) begin
               state_in = (probe_ff + HW'(1) == k_eff) ? bfdh_pkg::ST_DONE
                        : bfdh_pkg::ST_MOD;
            end
         end
         bfdh_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = bfdh_pkg::ST_IDLE;
         end
         default: state_in = bfdh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      bit_in = bit_ff;
      probe_in = probe_ff;
      clr_in = clr_ff;
      ph_in = ph_ff;
      all_in = all_ff;
      h2_in = h2_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we = 1'b0;
      ram_wd = 1'b0;
      ram_addr = rem_ff[AW-1:0];
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            clr_in = clr_ff + AW'(1);
         end
         bfdh_pkg::ST_HASH: begin
            all_in = 1'b1;
            probe_in = '0;
            bit_in = 6'd0;
            rem_in = 32'd0;
            acc_in = h1_w;
            quo_in = h1_w;
            h2_in = h2_w;
            ph_in = 2'd0;
         end
         bfdh_pkg::ST_MOD: begin
            bit_in = bit_ff + 6'd1;
            quo_in = {quo_ff[30:0], 1'b0};
            rem_in = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
         end
         bfdh_pkg::ST_PROBE: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) begin
               if (op_ff == bfdh_pkg::OP_INSERT) begin
                  ram_we = 1'b1;
                  ram_wd = 1'b1;
               end else if (!ram_rd) begin
                  all_in = 1'b0;
               end
               probe_in = probe_ff + HW'(1);
               acc_in = acc_ff + h2_ff;
               quo_in = acc_ff + h2_ff;
               rem_in = 32'd0;
               bit_in = 6'd0;
               ph_in = 2'd0;
            end
         end
         bfdh_pkg::ST_DONE: begin
            if ((!rsp_valid_ff || rsp_ready) && op_ff == bfdh_pkg::OP_QUERY) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            all_in = all_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfdh_pkg::ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (hstart) begin
         op_ff <= req_operation;
         key_ff <= req_key;
      end
      if (state_ff == bfdh_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_member_ff <= all_ff;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      probe_ff <= probe_in;
      ph_ff <= ph_in;
      all_ff <= all_in;
      h2_ff <= h2_in;
   end

   bfdh_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_bits (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wd),
      .rdata (ram_rd)
   );

   assign req_ready = (state_ff == bfdh_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_member = rsp_member_ff;

   `BF_ASSERT_IMP(a_rem_below_m, clock, reset, state_ff == bfdh_pkg::ST_PROBE,
      rem_ff < {{(32 - MW){1'b0}}, m_eff}, "probe index not reduced below num_bits")
   `BF_ASSERT_IMP(a_hash_only_in_hash, clock, reset, hctl.done,
      state_ff == bfdh_pkg::ST_HASH, "hash finished outside hash state")
   `BF_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_member_ff), "stalled result changed")
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for bloom_filter_double_hash_core
// depends on bfdh_pkg and the core rtl; holds its own bit array and xxhash32 predictor
module testbench;
   localparam int FILTER_BITS = 65536;
   localparam int SETTLE_CYCLES = 700;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 235;

   typedef struct {
      logic [4:0]  hashes;
      logic [16:0] bits;
      logic [3:0]  key_len;
      logic        op;
      logic [63:0] key;
      bit          known;
      logic        member;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [63:0] req_key;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_member;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   bit          filter_bits [FILTER_BITS];
   logic [4:0]  cur_hashes;
   logic [16:0] cur_bits;
   logic [3:0]  cur_key_len;
   logic        member_expected [$];
   int unsigned fail_count;
   int unsigned results_seen;
   bit          steady;

   stim_row_type dir_rows [20];
   logic [63:0]  key_pool [16];

   bloom_filter_double_hash_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_member(rsp_member),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd8 * 64'd4_000_000);
      $display("bloom_filter_double_hash_core verification failed");
      $finish;
   end

   function automatic logic [31:0] xxh32_key(input logic [63:0] key, input int unsigned len,
                                             input logic [31:0] seed);
      logic [31:0] h;
      logic [31:0] w;
      int unsigned p;
      h = seed + bfdh_pkg::XP5 + len;
      p = 0;
      while (p + 4 <= len) begin
         w = key[8*p +: 32];
         h = h + w * bfdh_pkg::XP3;
         h = {h[14:0], h[31:15]} * bfdh_pkg::XP4;
         p = p + 4;
      end
      while (p < len) begin
         w = {24'd0, key[8*p +: 8]};
         h = h + w * bfdh_pkg::XP5;
         h = {h[20:0], h[31:21]} * bfdh_pkg::XP1;
         p = p + 1;
      end
      h = h ^ (h >> 15);
      h = h * bfdh_pkg::XP2;
      h = h ^ (h >> 13);
      h = h * bfdh_pkg::XP3;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // sets the probed bits on insert, returns membership on query
   function automatic logic filter_probe(input logic op, input logic [63:0] key);
      int unsigned len;
      int unsigned nprobe;
      logic [31:0] m;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] idx;
      logic [31:0] pos;
      logic        all_set;
      len = (cur_key_len > 8) ? 8 : cur_key_len;
      nprobe = (cur_hashes > bfdh_pkg::MAX_HASHES_DEF) ? bfdh_pkg::MAX_HASHES_DEF : cur_hashes;
      m = (cur_bits == 0) ? 32'd1 : cur_bits;
      if (m > FILTER_BITS) m = FILTER_BITS;
      h1 = xxh32_key(key, len, bfdh_pkg::SEED_A);
      h2 = xxh32_key(key, len, bfdh_pkg::SEED_B);
      all_set = 1'b1;
      for (int unsigned i = 0; i < nprobe; i++) begin
         idx = i;
         pos = (h1 + idx * h2) % m;
         if (op == bfdh_pkg::OP_INSERT) filter_bits[pos[15:0]] = 1'b1;
         else if (!filter_bits[pos[15:0]]) all_set = 1'b0;
      end
      return all_set;
   endfunction

   // returns the bus to idle before it ends, so back-to-back writes never overlap
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // registers change only with the block idle; inserts leave no result, so settle too
   task automatic drain_block();
      req_valid <= 1'b0;
      while (member_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [4:0] k, input logic [16:0] m, input logic [3:0] len);
      drain_block();
      csr_write(bfdh_pkg::REG_NUM_HASHES, {27'd0, k});
      csr_write(bfdh_pkg::REG_NUM_BITS, {15'd0, m});
      csr_write(bfdh_pkg::REG_KEY_LENGTH, {28'd0, len});
      cur_hashes = k;
      cur_bits = m;
      cur_key_len = len;
   endtask

   // valid stays high across back-to-back transactions, except for random gaps outside the steady phase
   task automatic send_item(input logic op, input logic [63:0] key, input bit known,
                            input logic member);
      logic predicted;
      if (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key <= key;
      do @(posedge clock); while (!req_ready);
      predicted = filter_probe(op, key);
      if (op == bfdh_pkg::OP_QUERY) member_expected.push_back(known ? member : predicted);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      logic want;
      bit held;
      held = 0;
      results_seen = 0;
      fail_count = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (member_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected transaction: member %0b", rsp_member);
            end else begin
               want = member_expected.pop_front();
               if (rsp_member !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("member mismatch: expected %0b actual %0b", want, rsp_member);
               end
            end
         end
         if (results_seen == 300 && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= (steady || $urandom_range(99) >= 14);
         end
      end
   end

   initial begin
      logic [63:0] key;
      logic [4:0]  k;
      logic [16:0] m;
      int unsigned r;
      req_valid = 1'b0;
      req_operation = bfdh_pkg::OP_INSERT;
      req_key = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady = 0;
      reset = 1'b1;
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      cur_hashes = 5'd4;
      cur_bits = 17'd65536;
      cur_key_len = 4'd8;

      dir_rows = '{
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  64'h0, 1, 1'b0},  // empty filter
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  '1, 1, 1'b0},
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_INSERT, 64'h0, 0, 1'b0},
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  64'h0, 1, 1'b1},
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_INSERT, '1, 0, 1'b0},
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  '1, 1, 1'b1},
         '{5'd4,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  64'h0123456789abcdef, 0, 1'b0},
         '{5'd0,  17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  64'hdeadbeef, 1, 1'b1},   // no probes
         '{5'd0,  17'd65536,  4'd8,  bfdh_pkg::OP_INSERT, 64'h5, 0, 1'b0},
         '{5'd31, 17'd65536,  4'd8,  bfdh_pkg::OP_INSERT, 64'h5555aaaa5555aaaa, 0, 1'b0},
         '{5'd31, 17'd65536,  4'd8,  bfdh_pkg::OP_QUERY,  64'h5555aaaa5555aaaa, 1, 1'b1},
         '{5'd1,  17'd0,      4'd8,  bfdh_pkg::OP_INSERT, 64'h77, 0, 1'b0},
         '{5'd1,  17'd0,      4'd8,  bfdh_pkg::OP_QUERY,  64'h99, 1, 1'b1},   // all hit bit 0
         '{5'd16, 17'd1,      4'd8,  bfdh_pkg::OP_QUERY,  64'h1234, 1, 1'b1},
         '{5'd16, 17'd131071, 4'd8,  bfdh_pkg::OP_QUERY,  64'hfedcba9876543210, 0, 1'b0},
         '{5'd4,  17'd65536,  4'd0,  bfdh_pkg::OP_INSERT, 64'haaaa, 0, 1'b0},
         '{5'd4,  17'd65536,  4'd0,  bfdh_pkg::OP_QUERY,  64'h5555, 1, 1'b1},  // empty hash input
         '{5'd4,  17'd65536,  4'd15, bfdh_pkg::OP_QUERY,  64'h8000000000000001, 0, 1'b0},
         '{5'd4,  17'd65536,  4'd1,  bfdh_pkg::OP_QUERY,  64'hffffffffffffff00, 0, 1'b0},
         '{5'd3,  17'd65535,  4'd5,  bfdh_pkg::OP_QUERY,  64'h00000000000000ff, 0, 1'b0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].hashes != cur_hashes || dir_rows[i].bits != cur_bits ||
             dir_rows[i].key_len != cur_key_len)
            set_config(dir_rows[i].hashes, dir_rows[i].bits, dir_rows[i].key_len);
         send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].known, dir_rows[i].member);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         r = $urandom_range(9);
         if (r <= 6) k = 5'($urandom_range(4, 1));
         else if (r == 7) k = 5'd0;
         else if (r == 8) k = 5'($urandom_range(16, 5));
         else k = 5'($urandom_range(31, 17));
         r = $urandom_range(4);
         case (r)
            0: m = $urandom_range(1) ? 17'd0 : 17'd1;
            1: m = 17'($urandom_range(64, 2));
            2: m = 17'($urandom_range(4096, 65));
            3: m = 17'd65536;
            default: m = 17'($urandom_range(131071, 65537));
         endcase
         set_config(k, m, 4'($urandom_range(15)));
         foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
         steady = (ph == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mostly keys from the phase pool so queries find earlier inserts
            if ($urandom_range(99) < 70) key = key_pool[4'($urandom_range(15))];
            else key = {$urandom, $urandom};
            send_item(1'($urandom_range(1)), key, 0, 1'b0);
         end
      end
      steady = 0;
      drain_block();

      if (fail_count == 0) $display("bloom_filter_double_hash_core verification clean");
      else $display("bloom_filter_double_hash_core verification failed");
      $finish;
   end
endmodule
